// ===== sv/sha_pkg.sv =====
`default_nettype none

package sha_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned CountW    = 61;
  localparam int unsigned BitLenW   = 64;

  localparam logic [7:0] PadMark     = 8'h80;
  localparam logic [5:0] LenStartPos = 6'd56;
  localparam logic [5:0] LastPos     = 6'd63;
  localparam logic [5:0] LastRound   = 6'd63;
  localparam logic [2:0] LastWord    = 3'd7;

  typedef struct packed {
    logic               has_byte;
    logic [7:0]         data;
    logic               is_end;
    logic [BitLenW-1:0] bit_len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_ctl_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

`default_nettype wire

// ===== sv/sha_front.sv =====
`default_nettype none

module sha_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          byte_present_i,
  input  wire logic          message_end_i,
  input  wire logic          cmd_full_i,
  output logic               cmd_push_o,
  output sha_pkg::cmd_t      cmd_o
);
  import sha_pkg::*;

  logic [CountW-1:0] count_q, count_d, count_inc;
  logic              take, add_byte;

  assign full      = cmd_full_i;
  assign take      = push && !cmd_full_i;
  assign add_byte  = byte_present_i && (count_q != {CountW{1'b1}});
  assign count_inc = add_byte ? count_q + 1'b1 : count_q;

  assign cmd_push_o       = take && (add_byte || message_end_i);
  assign cmd_o.has_byte   = add_byte;
  assign cmd_o.data       = data_byte_i;
  assign cmd_o.is_end     = message_end_i;
  assign cmd_o.bit_len    = {count_inc, 3'b000};

  always_comb begin
    count_d = count_q;
    if (take) begin
      count_d = message_end_i ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sha_cmd_fifo.sv =====
`default_nettype none

module sha_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sha_pkg::cmd_t  data_i,
  input  wire logic           pop_i,
  output sha_pkg::cmd_t       data_o,
  output sha_pkg::fifo_ctl_t  ctl_o
);
  import sha_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FifoPtrW:0]   cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign ctl_o.full  = (cnt_q == (FifoPtrW + 1)'(FifoDepth));
  assign ctl_o.empty = (cnt_q == '0);

  assign do_wr  = push_i && !ctl_o.full;
  assign do_rd  = pop_i && !ctl_o.empty;
  assign data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sha_back.sv =====
`default_nettype none

module sha_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sha_pkg::cmd_t  cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  wire logic           pop,
  output logic [31:0]         digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_OUT
  } state_e;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  state_e     state_q;
  logic [5:0] pos_q;
  logic [5:0] rnd_q;
  logic [2:0] idx_q;
  logic       first_q, len_ph_q, pad_q, final_q;
  word_t      chain_q [8];

  logic [23:0]        acc_q;
  logic [BitLenW-1:0] len_q;
  word_t              sr_q [16];
  word_t              v_q [8];

  logic       ins_valid, blk_done, len_byte;
  logic [7:0] ins_byte, pad_byte;
  word_t      s0, s1, w_new, t1, t2, ch, maj, sum0, sum1;

  assign cmd_pop_o = (state_q == ST_IDLE) && !cmd_empty_i;

  assign len_byte = !first_q && ((pos_q == LenStartPos) || len_ph_q);
  assign pad_byte = first_q ? PadMark : (len_byte ? len_q[BitLenW-1 -: 8] : 8'h00);

  always_comb begin
    ins_valid = 1'b0;
    ins_byte  = pad_byte;
    if (state_q == ST_PAD) begin
      ins_valid = 1'b1;
    end else if (cmd_pop_o) begin
      ins_valid = cmd_i.has_byte;
      ins_byte  = cmd_i.data;
    end
  end

  assign blk_done = ins_valid && (pos_q == LastPos);

  assign s0    = rotr(sr_q[1], 7) ^ rotr(sr_q[1], 18) ^ (sr_q[1] >> 3);
  assign s1    = rotr(sr_q[14], 17) ^ rotr(sr_q[14], 19) ^ (sr_q[14] >> 10);
  assign w_new = sr_q[0] + s0 + sr_q[9] + s1;
  assign sum1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign sum0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + sum1 + ch + RoundK[rnd_q] + sr_q[0];
  assign t2    = sum0 + maj;

  assign empty         = (state_q != ST_OUT);
  assign digest_word_o = chain_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LastWord);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= '0;
      rnd_q    <= '0;
      idx_q    <= '0;
      first_q  <= 1'b0;
      len_ph_q <= 1'b0;
      pad_q    <= 1'b0;
      final_q  <= 1'b0;
      chain_q  <= InitHash;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o) begin
            if (cmd_i.has_byte) begin
              pos_q <= pos_q + 1'b1;
            end
            pad_q    <= cmd_i.is_end;
            first_q  <= cmd_i.is_end;
            len_ph_q <= 1'b0;
            if (blk_done) begin
              state_q <= ST_ROUND;
              rnd_q   <= '0;
            end else if (cmd_i.is_end) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == LastRound) begin
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= chain_q[i] + v_q[i];
          end
          if (final_q) begin
            state_q <= ST_OUT;
            idx_q   <= '0;
          end else if (pad_q) begin
            state_q <= ST_PAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_PAD: begin
          pos_q   <= pos_q + 1'b1;
          first_q <= 1'b0;
          if (len_byte) begin
            len_ph_q <= 1'b1;
          end
          if (blk_done) begin
            state_q <= ST_ROUND;
            rnd_q   <= '0;
            final_q <= len_byte;
          end
        end
        ST_OUT: begin
          if (pop) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == LastWord) begin
              chain_q  <= InitHash;
              state_q  <= ST_IDLE;
              final_q  <= 1'b0;
              pad_q    <= 1'b0;
              len_ph_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_valid) begin
      acc_q <= {acc_q[15:0], ins_byte};
      if (pos_q[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          sr_q[i] <= sr_q[i+1];
        end
        sr_q[15] <= {acc_q, ins_byte};
      end
    end
    if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sr_q[i] <= sr_q[i+1];
      end
      sr_q[15] <= w_new;
      v_q[7]   <= v_q[6];
      v_q[6]   <= v_q[5];
      v_q[5]   <= v_q[4];
      v_q[4]   <= v_q[3] + t1;
      v_q[3]   <= v_q[2];
      v_q[2]   <= v_q[1];
      v_q[1]   <= v_q[0];
      v_q[0]   <= t1 + t2;
    end
    if (blk_done) begin
      v_q <= chain_q;
    end
    if (cmd_pop_o && cmd_i.is_end) begin
      len_q <= cmd_i.bit_len;
    end else if ((state_q == ST_PAD) && len_byte) begin
      len_q <= {len_q[BitLenW-9:0], 8'h00};
    end
  end

`ifndef ASSERT_OFF
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == LastRound) |=> (state_q == ST_FINAL))
    else $error("Compression did not finish after the last round.");

  a_out_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> (pos_q == '0 && !first_q))
    else $error("Digest output started with a partly filled block.");

  a_chain_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && pop && idx_q == LastWord)
      |=> (chain_q[0] == InitHash[0] && chain_q[7] == InitHash[7] && state_q == ST_IDLE))
    else $error("Chaining state was not restored after the digest transfer.");
`endif

endmodule

`default_nettype wire

// ===== sv/sha256_byte_stream_hasher_core.sv =====
// SHA-256 over a byte stream.
// Input channel: an item transfers when push is high and full is low. It carries one
// byte (data_byte_i, used when byte_present_i is high) and an end-of-message flag.
// Result channel: while empty is low the oldest digest word is on digest_word_o,
// word_index_o and last_word_o; it transfers when pop is high.
// A front stage keeps the byte count and sends each item with a byte or an end of
// message through a four-entry command queue to the compression engine, so input
// keeps flowing while the engine works or the result side stalls; full rises only
// when that queue is full. Every 64th byte starts a block compression (64 rounds,
// one at a time in the shared round unit, then the chaining add). An end of message
// inserts the padding bytes (9 to 72) and runs one or two block compressions before
// the first digest word, then the eight words follow one per cycle as they are
// popped. A stalled receiver holds the engine in digest output; the queue still
// accepts up to four items.
// Reset clears the byte count, the queue and the engine and loads the initial hash.
`default_nettype none

module sha256_byte_stream_hasher_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        message_end_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import sha_pkg::*;

  cmd_t      front_cmd, queue_cmd;
  logic      front_push, back_pop;
  fifo_ctl_t queue_ctl;

  sha_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .cmd_full_i     (queue_ctl.full),
    .cmd_push_o     (front_push),
    .cmd_o          (front_cmd)
  );

  sha_cmd_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_cmd),
    .pop_i  (back_pop),
    .data_o (queue_cmd),
    .ctl_o  (queue_ctl)
  );

  sha_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (queue_cmd),
    .cmd_empty_i   (queue_ctl.empty),
    .cmd_pop_o     (back_pop),
    .empty         (empty),
    .pop           (pop),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

`default_nettype wire

// ===== verif/sha256_byte_stream_hasher_core_tb.sv =====
`default_nettype none

module sha256_byte_stream_hasher_core_tb;

  localparam int WatchLimit = 4000;
  localparam int TailCycles = 200;
  localparam int ItemsPerPhase = 75;
  localparam bit [63:0] MaxBytes = 64'h1FFF_FFFF_FFFF_FFFF;

  localparam bit [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam int SendIdlePct [4] = '{0, 74, 0, 13};
  localparam int RecvStallPct [4] = '{0, 0, 74, 13};

  typedef struct {
    bit [31:0] word;
    bit [2:0]  index;
    bit        last;
  } digest_word_t;

  class sha256_digest_scoreboard;
    bit [31:0] chain [8] = StartHash;
    bit [7:0] blk [64];
    bit [31:0] sched [16];
    bit [63:0] nbytes = 0;
    digest_word_t digest_q [$];
    int errors = 0;

    function bit [31:0] rotr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      bit [31:0] v [8];
      bit [31:0] w, t1, t2, x15, x2, s0, s1;
      v = chain;
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          w = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end else begin
          x15 = sched[(t + 1) % 16];
          x2 = sched[(t + 14) % 16];
          s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
          s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
          w = sched[t % 16] + s0 + sched[(t + 9) % 16] + s1;
        end
        sched[t % 16] = w;
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void put_byte(bit [5:0] pos, bit [7:0] b);
      blk[pos] = b;
      if (pos == 6'd63) compress_block();
    endfunction

    // Bytes past the saturated length are dropped; the end of a message pads and
    // queues all eight digest words, then restarts the chain.
    function void absorb_item(bit [7:0] b, bit present, bit msg_end);
      bit [63:0] bits;
      bit [5:0] pos;
      digest_word_t dw;
      if (present && nbytes < MaxBytes) begin
        put_byte(nbytes[5:0], b);
        nbytes++;
      end
      if (!msg_end) return;
      bits = nbytes << 3;
      pos = nbytes[5:0];
      put_byte(pos, 8'h80);
      pos++;
      while (pos != 6'd56) begin
        put_byte(pos, 8'h00);
        pos++;
      end
      for (int i = 0; i < 8; i++) put_byte(6'(56 + i), bits[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        dw.word = chain[i];
        dw.index = 3'(i);
        dw.last = (i == 7);
        digest_q.push_back(dw);
      end
      chain = StartHash;
      nbytes = 0;
    endfunction

    function void check_digest_word(bit [31:0] word, bit [2:0] index, bit last);
      digest_word_t dw;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %0b",
                 $time, word, index, last);
        errors++;
        return;
      end
      dw = digest_q.pop_front();
      if (word !== dw.word) begin
        $display("%0t: digest_word expected %h actual %h", $time, dw.word, word);
        errors++;
      end
      if (index !== dw.index) begin
        $display("%0t: word_index expected %0d actual %0d", $time, dw.index, index);
        errors++;
      end
      if (last !== dw.last) begin
        $display("%0t: last_word expected %0b actual %0b", $time, dw.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] data_byte_i = 8'h00;
  logic byte_present_i = 1'b0;
  logic message_end_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0] word_index_o;
  logic last_word_o;

  sha256_digest_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  sha256_byte_stream_hasher_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .message_end_i  (message_end_i),
    .empty          (empty),
    .pop            (pop),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_digest_word(digest_word_o, word_index_o, last_word_o);
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("sha256_byte_stream_hasher_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic present, input logic msg_end);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= b;
    byte_present_i <= present;
    message_end_i <= msg_end;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.absorb_item(b, present, msg_end);
    if (present || msg_end) items_sent++;
  endtask

  task automatic send_message(input int len);
    bit joined;
    joined = (len > 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, joined && (i == len - 1));
    end
    if (!joined) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SendIdlePct[ph];
      recv_stall_pct = RecvStallPct[ph];
      while (items_sent < ItemsPerPhase * (ph + 1)) begin
        case ($urandom_range(9))
          0, 1: begin
            len = 55 + $urandom_range(10);
          end
          2: begin
            len = 66 + $urandom_range(64);
          end
          default: begin
            len = $urandom_range(20);
          end
        endcase
        send_message(len);
      end
      if (ph == 0) begin
        push <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sha256_byte_stream_hasher_core: match");
    end else begin
      $display("sha256_byte_stream_hasher_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
